>>> src/cgr_pkg.sv
// Shared types and constants of the clipped glyph rasterizer.
package cgr_pkg;

  localparam int unsigned CODE_W  = 7;   // character code after masking
  localparam int unsigned ROW_W   = 3;   // row or column within a glyph
  localparam int unsigned POS_W   = 12;
  localparam int unsigned COORD_W = 13;  // position plus glyph offset
  localparam int unsigned LIM_W   = 14;  // clip limit, holds the dimension cap
  localparam int unsigned PITCH_W = 16;
  localparam int unsigned PROD_W  = COORD_W + PITCH_W;
  localparam int unsigned COLOR_W = 32;
  localparam int unsigned BASE_W  = 32;
  localparam int unsigned ADDR_W  = 33;
  localparam int unsigned GADDR_W = CODE_W + ROW_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE   = 3'd4;

  localparam logic [ROW_W-1:0] LAST_ROW = 3'd7;
  localparam logic [ROW_W-1:0] LAST_COL = 3'd7;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_DRAW = 2'd1,
    CMD_PLOT = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_ADD,
    BK_WALK,
    BK_FLUSH
  } bk_state_t;

  typedef struct packed {
    logic               enable;
    logic [LIM_W-1:0]   width_lim;
    logic [LIM_W-1:0]   height_lim;
    logic [PITCH_W-1:0] pitch;
    logic [BASE_W-1:0]  base;
  } cfg_t;

  typedef struct packed {
    logic               is_draw;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [CODE_W-1:0]  code;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    logic               with_bg;
  } desc_t;

  typedef struct packed {
    logic               en;
    logic [GADDR_W-1:0] addr;
    logic [7:0]         data;
  } glyph_wr_t;

endpackage

>>> src/cgr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cgr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/cgr_front.sv
// Front end: configuration registers, command intake, glyph loads and queue push.
module cgr_front #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cgr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cgr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         command,
  input  logic [cgr_pkg::POS_W-1:0]          pos_x,
  input  logic [cgr_pkg::POS_W-1:0]          pos_y,
  input  logic [7:0]                         char_code,
  input  logic [cgr_pkg::ROW_W-1:0]          glyph_row,
  input  logic [7:0]                         glyph_bits,
  input  logic [cgr_pkg::COLOR_W-1:0]        foreground_color,
  input  logic [cgr_pkg::COLOR_W-1:0]        background_color,
  input  logic                               draw_background,
  input  logic                               queue_full,
  input  logic                               draw_busy,
  output logic                               push,
  output cgr_pkg::desc_t                     push_desc,
  output cgr_pkg::glyph_wr_t                 glyph_wr,
  output cgr_pkg::cfg_t                      cfg
);

  localparam logic [cgr_pkg::LIM_W-1:0] DimLimit = cgr_pkg::LIM_W'(MAX_DIM);

  cgr_pkg::cmd_t cmd;
  logic          accept;
  logic [cgr_pkg::LIM_W-1:0] dim_in;
  logic [cgr_pkg::LIM_W-1:0] dim_lim;

  assign cfg_ready = 1'b1;
  assign cmd       = cgr_pkg::cmd_t'(command);

  // Hold a load while a draw may still read the store.
  assign in_stall = queue_full || ((cmd == cgr_pkg::CMD_LOAD) && draw_busy);
  assign accept   = in_valid && !in_stall;

  assign dim_in  = {1'b0, cfg_data[cgr_pkg::COORD_W-1:0]};
  assign dim_lim = (dim_in > DimLimit) ? DimLimit : dim_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cgr_pkg::REG_ENABLE:       cfg.enable     <= cfg_data[0];
        cgr_pkg::REG_FRAME_WIDTH:  cfg.width_lim  <= dim_lim;
        cgr_pkg::REG_FRAME_HEIGHT: cfg.height_lim <= dim_lim;
        cgr_pkg::REG_ROW_PITCH:    cfg.pitch      <= cfg_data[cgr_pkg::PITCH_W-1:0];
        cgr_pkg::REG_FRAME_BASE:   cfg.base       <= cfg_data[cgr_pkg::BASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    push          = 1'b0;
    glyph_wr.en   = 1'b0;
    glyph_wr.addr = {char_code[cgr_pkg::CODE_W-1:0], glyph_row};
    glyph_wr.data = glyph_bits;
    case (cmd)
      cgr_pkg::CMD_LOAD: glyph_wr.en = accept;
      cgr_pkg::CMD_DRAW,
      cgr_pkg::CMD_PLOT: push = accept && cfg.enable;
      default: ;
    endcase
  end

  assign push_desc.is_draw = (cmd == cgr_pkg::CMD_DRAW);
  assign push_desc.pos_x   = pos_x;
  assign push_desc.pos_y   = pos_y;
  assign push_desc.code    = char_code[cgr_pkg::CODE_W-1:0];
  assign push_desc.fg      = foreground_color;
  assign push_desc.bg      = background_color;
  assign push_desc.with_bg = draw_background;

endmodule

>>> src/cgr_queue.sv
// Two-entry command queue between the front and back ends.
module cgr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cgr_pkg::desc_t push_desc,
  input  logic           pop,
  output cgr_pkg::desc_t head,
  output logic           empty,
  output logic           full
);

  cgr_pkg::desc_t slot [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign head  = slot[rd_ptr];
  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_desc;
    end
  end

endmodule

>>> src/cgr_back.sv
// Back end: walks glyph rows and columns, clips, forms addresses and emits words.
module cgr_back (
  input  logic                                clk,
  input  logic                                rst,
  input  cgr_pkg::cfg_t                       cfg,
  input  cgr_pkg::desc_t                      head,
  input  logic                                empty,
  output logic                                pop,
  output logic                                rd_en,
  output logic [cgr_pkg::GADDR_W-1:0]         rd_addr,
  input  logic [7:0]                          rd_data,
  output logic                                busy,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [cgr_pkg::ADDR_W-1:0]          write_address,
  output logic [cgr_pkg::COLOR_W-1:0]         pixel_value,
  output logic                                last
);

  cgr_pkg::bk_state_t state;
  cgr_pkg::bk_state_t state_next;
  cgr_pkg::desc_t     desc;

  logic [cgr_pkg::ROW_W-1:0]   row;
  logic [cgr_pkg::ROW_W-1:0]   col;
  logic [cgr_pkg::PROD_W-1:0]  prod;
  logic                        yok_pend;
  logic [7:0]                  bits_cur;
  logic [cgr_pkg::ADDR_W-1:0]  rowaddr_cur;
  logic [cgr_pkg::ADDR_W-1:0]  rowaddr_nxt;
  logic                        yok_cur;
  logic                        yok_nxt;
  logic                        pend_valid;
  logic [cgr_pkg::ADDR_W-1:0]  pend_addr;
  logic [cgr_pkg::COLOR_W-1:0] pend_val;

  logic                         mul_en;
  logic                         walk_adv;
  logic                         out_load;
  logic                         out_last;
  logic                         out_free;
  logic [3:0]                   mul_row;
  logic [cgr_pkg::COORD_W-1:0]  y_mul;
  logic [cgr_pkg::COORD_W-1:0]  x_pos;
  logic [cgr_pkg::ADDR_W-1:0]   row_base;
  logic [cgr_pkg::ADDR_W-1:0]   pix_addr;
  logic [cgr_pkg::COLOR_W-1:0]  pix_val;
  logic                         bit_set;
  logic                         in_window;
  logic                         emit;
  logic                         cmd_end;

  assign busy     = (state != cgr_pkg::BK_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign mul_row  = (state == cgr_pkg::BK_WALK) ? (4'(row) + 4'd1) : 4'd0;
  assign y_mul    = cgr_pkg::COORD_W'(desc.pos_y) + cgr_pkg::COORD_W'(mul_row);
  assign row_base = cgr_pkg::ADDR_W'(cfg.base) + cgr_pkg::ADDR_W'(prod);

  assign x_pos    = cgr_pkg::COORD_W'(desc.pos_x) + cgr_pkg::COORD_W'(col);
  assign bit_set  = bits_cur[col];
  assign in_window = ({1'b0, x_pos} < cfg.width_lim) && yok_cur;
  // A plot is a single pixel at the first position of the walk.
  assign emit     = in_window && (!desc.is_draw || bit_set || desc.with_bg);
  assign cmd_end  = !desc.is_draw || ((row == cgr_pkg::LAST_ROW) && (col == cgr_pkg::LAST_COL));
  assign pix_addr = rowaddr_cur + cgr_pkg::ADDR_W'({x_pos, 2'b00});
  assign pix_val  = (!desc.is_draw || bit_set) ? desc.fg : desc.bg;

  assign rd_addr  = (state == cgr_pkg::BK_IDLE) ? {head.code, 3'd0}
                                                : {desc.code, row + 3'd1};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cgr_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    rd_en      = 1'b0;
    mul_en     = 1'b0;
    walk_adv   = 1'b0;
    out_load   = 1'b0;
    out_last   = 1'b0;
    case (state)
      cgr_pkg::BK_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          rd_en      = 1'b1;
          state_next = cgr_pkg::BK_MUL;
        end
      end
      cgr_pkg::BK_MUL: begin
        mul_en     = 1'b1;
        state_next = cgr_pkg::BK_ADD;
      end
      cgr_pkg::BK_ADD: begin
        state_next = cgr_pkg::BK_WALK;
      end
      cgr_pkg::BK_WALK: begin
        // Prefetch the next row and its address while this one is walked.
        if (col == 3'd0) begin
          mul_en = 1'b1;
          rd_en  = desc.is_draw && (row != cgr_pkg::LAST_ROW);
        end
        if (out_free) begin
          walk_adv = 1'b1;
          out_load = emit && pend_valid;
          if (cmd_end) begin
            state_next = cgr_pkg::BK_FLUSH;
          end
        end
      end
      cgr_pkg::BK_FLUSH: begin
        if (!pend_valid) begin
          state_next = cgr_pkg::BK_IDLE;
        end else if (out_free) begin
          out_load   = 1'b1;
          out_last   = 1'b1;
          state_next = cgr_pkg::BK_IDLE;
        end
      end
      default: state_next = cgr_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      desc <= head;
      row  <= '0;
      col  <= '0;
    end
    if (mul_en) begin
      prod     <= cgr_pkg::PROD_W'(y_mul) * cgr_pkg::PROD_W'(cfg.pitch);
      yok_pend <= ({1'b0, y_mul} < cfg.height_lim);
    end
    if (state == cgr_pkg::BK_ADD) begin
      bits_cur    <= rd_data;
      rowaddr_cur <= row_base;
      yok_cur     <= yok_pend;
    end
    if ((state == cgr_pkg::BK_WALK) && (col == 3'd1)) begin
      rowaddr_nxt <= row_base;
      yok_nxt     <= yok_pend;
    end
    if (walk_adv) begin
      col <= col + 3'd1;
      if (col == cgr_pkg::LAST_COL) begin
        row         <= row + 3'd1;
        bits_cur    <= rd_data;
        rowaddr_cur <= rowaddr_nxt;
        yok_cur     <= yok_nxt;
      end
      if (emit) begin
        pend_addr <= pix_addr;
        pend_val  <= pix_val;
      end
    end
    if (out_load) begin
      write_address <= pend_addr;
      pixel_value   <= pend_val;
      last          <= out_last;
    end
  end

  // Hold one pixel back so the final word of a command can carry last.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (walk_adv && emit) begin
        pend_valid <= 1'b1;
      end else if (out_load) begin
        pend_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> src/clipped_glyph_rasterizer_core.sv
// Top level of the clipped glyph rasterizer: front end, queue, back end and glyph store.
//
//  channel | handshake            | word
//  --------+----------------------+--------------------------------------------------
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in      | in_valid/in_stall    | command, pos_x, pos_y, char_code, glyph_row, ...
//  out     | out_valid/out_stall  | write_address, pixel_value, last
//
// A draw runs pop, multiply, add, a walk over the 64 glyph positions and flush in the back
// end; at most one pixel leaves per cycle while out_stall is low, set by the single output
// port. A plot walks one position. Loads and dropped commands stay in the front end; a
// load waits until the queue is empty and the back end is idle. Reset is synchronous and
// clears control state, not data or the glyph store. A stalled output holds the back end.
module clipped_glyph_rasterizer_core #(
  parameter int unsigned GLYPH_COUNT = 128,
  parameter int unsigned MAX_DIM     = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cgr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cgr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         command,
  input  logic [cgr_pkg::POS_W-1:0]          pos_x,
  input  logic [cgr_pkg::POS_W-1:0]          pos_y,
  input  logic [7:0]                         char_code,
  input  logic [cgr_pkg::ROW_W-1:0]          glyph_row,
  input  logic [7:0]                         glyph_bits,
  input  logic [cgr_pkg::COLOR_W-1:0]        foreground_color,
  input  logic [cgr_pkg::COLOR_W-1:0]        background_color,
  input  logic                               draw_background,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [cgr_pkg::ADDR_W-1:0]         write_address,
  output logic [cgr_pkg::COLOR_W-1:0]        pixel_value,
  output logic                               last
);

  localparam int unsigned StoreDepth = GLYPH_COUNT * 8;
  localparam int unsigned StoreAw    = $clog2(StoreDepth);

  cgr_pkg::cfg_t      cfg;
  cgr_pkg::desc_t     push_desc;
  cgr_pkg::desc_t     head;
  cgr_pkg::glyph_wr_t glyph_wr;
  logic               push;
  logic               pop;
  logic               q_empty;
  logic               q_full;
  logic               bk_busy;
  logic               draw_busy;
  logic               rd_en;
  logic [cgr_pkg::GADDR_W-1:0] rd_addr;
  logic [7:0]                  rd_data;

  assign draw_busy = !q_empty || bk_busy;

  cgr_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .command          (command),
    .pos_x            (pos_x),
    .pos_y            (pos_y),
    .char_code        (char_code),
    .glyph_row        (glyph_row),
    .glyph_bits       (glyph_bits),
    .foreground_color (foreground_color),
    .background_color (background_color),
    .draw_background  (draw_background),
    .queue_full       (q_full),
    .draw_busy        (draw_busy),
    .push             (push),
    .push_desc        (push_desc),
    .glyph_wr         (glyph_wr),
    .cfg              (cfg)
  );

  cgr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  cgr_ram #(
    .WIDTH (8),
    .DEPTH (StoreDepth)
  ) u_glyph_store (
    .clk     (clk),
    .wr_en   (glyph_wr.en),
    .wr_addr (StoreAw'(glyph_wr.addr)),
    .wr_data (glyph_wr.data),
    .rd_en   (rd_en),
    .rd_addr (StoreAw'(rd_addr)),
    .rd_data (rd_data)
  );

  cgr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .head          (head),
    .empty         (q_empty),
    .pop           (pop),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .busy          (bk_busy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .write_address (write_address),
    .pixel_value   (pixel_value),
    .last          (last)
  );

endmodule
